// File: rtl/core/sosc_pkg.sv
package sosc_pkg;

    localparam int CORDIC_STEPS = 24;
    // x, y in Q30 and z in 2^-32 turn all fit comfortably in 34 signed bits
    localparam int CW = 34;
    localparam int ANGLE_BITS = 32;
    localparam int AMP_BITS = 15;
    localparam int INC_BITS = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE = 2'd1;

    localparam logic [INC_BITS-1:0] PHASE_INCREMENT_RESET = 32'd42852281;
    localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET = 15'd16384;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    localparam angle_t ANGLE_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10680094, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
        logic                 last;
    } cordic_word_t;

endpackage

// File: rtl/core/sosc_cordic_cell.sv
module sosc_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  sosc_pkg::cordic_word_t in_word,
    output logic                  out_valid,
    output sosc_pkg::cordic_word_t out_word
);

    localparam logic signed [sosc_pkg::CW-1:0] ANGLE =
        $signed(sosc_pkg::CW'(sosc_pkg::ANGLE_TABLE[STEP]));

    logic                   valid_reg;
    sosc_pkg::cordic_word_t word_reg;
    sosc_pkg::cordic_word_t word_next;
    logic signed [sosc_pkg::CW-1:0] dx;
    logic signed [sosc_pkg::CW-1:0] dy;

    assign dx = in_word.y >>> STEP;
    assign dy = in_word.x >>> STEP;

    always_comb
    begin
        word_next = in_word;
        if (!in_word.z[sosc_pkg::CW-1])
        begin
            word_next.x = in_word.x - dx;
            word_next.y = in_word.y + dy;
            word_next.z = in_word.z - ANGLE;
        end
        else
        begin
            word_next.x = in_word.x + dx;
            word_next.y = in_word.y - dy;
            word_next.z = in_word.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word = word_reg;

endmodule

// File: rtl/core/sosc_scaler.sv
module sosc_scaler #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  sosc_pkg::cordic_word_t        in_word,
    input  logic [sosc_pkg::AMP_BITS-1:0] amplitude,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last
);

    localparam int PW = sosc_pkg::CW + sosc_pkg::AMP_BITS + 1;
    localparam int SH = 46 - SAMPLE_BITS;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'd1 << (SH - 1));
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_LO = PW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic                            sine_valid_reg;
    logic signed [sosc_pkg::CW-1:0]  sine_reg;
    logic                            sine_last_reg;
    logic                            prod_valid_reg;
    logic signed [PW-1:0]            prod_reg;
    logic signed [PW-1:0]            prod_next;
    logic                            prod_last_reg;
    logic signed [PW-1:0]            rounded;
    logic signed [sosc_pkg::AMP_BITS:0] amp_s;

    assign amp_s = $signed({1'b0, amplitude});
    assign prod_next = sine_reg * amp_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sine_valid_reg <= in_valid;
            prod_valid_reg <= sine_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // undo the half-turn fold
            sine_reg <= in_word.flip ? -in_word.y : in_word.y;
            sine_last_reg <= in_word.last;
            prod_reg <= prod_next;
            prod_last_reg <= sine_last_reg;
        end
    end

    assign rounded = (prod_reg + ROUND_HALF) >>> SH;

    always_comb
    begin
        if (rounded > SAT_HI)
        begin
            sample = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            sample = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sample = rounded[SAMPLE_BITS-1:0];
        end
    end

    assign out_valid = prod_valid_reg;
    assign last = prod_last_reg;

endmodule

// File: rtl/core/sine_oscillator.sv
// Stereo sine oscillator: each accepted item is one frame tick and yields one
// frame of amplitude * sin(phase) on both channels, with last copied from
// last_of_block. The phase accumulator is read for the frame and then
// advances by phase_increment. The sine comes from a row of 24 CORDIC cells,
// one rotation per cell, so the block takes one item every cycle when not
// stalled. Stages: phase fold, 24 cells, sign fix, multiply, output register.
// A stalled output register holds the whole pipeline, and in_stall follows
// it. Write phase_increment and amplitude only while no frames are in flight.
module sine_oscillator #(
    parameter int PHASE_BITS = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sosc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sosc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                last_of_block,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       left_sample,
    output logic signed [SAMPLE_BITS-1:0]       right_sample,
    output logic                                last
);

    localparam int STEPS = sosc_pkg::CORDIC_STEPS;

    logic [sosc_pkg::INC_BITS-1:0] phase_increment_reg;
    logic [sosc_pkg::AMP_BITS-1:0] amplitude_reg;
    logic [PHASE_BITS-1:0]         phase_acc_reg;
    logic [PHASE_BITS-1:0]         phase_inc;
    sosc_pkg::angle_t              angle;
    sosc_pkg::angle_t              folded;
    logic                          fold_flip;
    logic                          adv;
    logic                          accept;

    logic                          fold_valid_reg;
    sosc_pkg::cordic_word_t        fold_reg;

    logic                          cell_valid [STEPS+1];
    sosc_pkg::cordic_word_t        cell_word [STEPS+1];

    logic                          scale_valid;
    logic signed [SAMPLE_BITS-1:0] scale_sample;
    logic                          scale_last;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign accept = in_valid && adv;

    assign phase_inc = PHASE_BITS'(phase_increment_reg);

    generate
        if (PHASE_BITS >= sosc_pkg::ANGLE_BITS)
        begin : g_angle_top
            assign angle = phase_acc_reg[PHASE_BITS-1 -: sosc_pkg::ANGLE_BITS];
        end
        else
        begin : g_angle_pad
            assign angle = {phase_acc_reg, {(sosc_pkg::ANGLE_BITS - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // second and third quadrants: move by half a turn, negate at the end
    assign fold_flip = angle[31] ^ angle[30];
    assign folded = {angle[31] ^ fold_flip, angle[30:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_increment_reg <= sosc_pkg::PHASE_INCREMENT_RESET;
            amplitude_reg <= sosc_pkg::AMPLITUDE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sosc_pkg::REG_PHASE_INCREMENT:
                    phase_increment_reg <= cfg_data[sosc_pkg::INC_BITS-1:0];
                sosc_pkg::REG_AMPLITUDE:
                    amplitude_reg <= cfg_data[sosc_pkg::AMP_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            fold_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_acc_reg <= phase_acc_reg + phase_inc;
            end
            if (adv)
            begin
                fold_valid_reg <= in_valid;
                out_valid_reg <= scale_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_reg.x <= sosc_pkg::CORDIC_X0;
            fold_reg.y <= '0;
            fold_reg.z <= sosc_pkg::CW'($signed(folded));
            fold_reg.flip <= fold_flip;
            fold_reg.last <= last_of_block;
            sample_reg <= scale_sample;
            last_reg <= scale_last;
        end
    end

    assign cell_valid[0] = fold_valid_reg;
    assign cell_word[0] = fold_reg;

    generate
        for (genvar i = 0; i < STEPS; i++)
        begin : g_cell
            sosc_cordic_cell #(
                .STEP(i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .in_valid (cell_valid[i]),
                .in_word  (cell_word[i]),
                .out_valid(cell_valid[i+1]),
                .out_word (cell_word[i+1])
            );
        end
    endgenerate

    sosc_scaler #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scaler (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (cell_valid[STEPS]),
        .in_word  (cell_word[STEPS]),
        .amplitude(amplitude_reg),
        .out_valid(scale_valid),
        .sample   (scale_sample),
        .last     (scale_last)
    );

    assign out_valid = out_valid_reg;
    assign left_sample = sample_reg;
    assign right_sample = sample_reg;
    assign last = last_reg;

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> phase_acc_reg == $past(phase_acc_reg + phase_inc))
        else $error("phase accumulator did not advance by the increment");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_acc_reg))
        else $error("phase accumulator moved without an item");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(scale_valid))
        else $error("output item appeared without a scaled sample");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(fold_valid_reg) && $stable(scale_valid))
        else $error("pipeline moved while the output was held");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [sosc_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [sosc_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;
    localparam int ROT_STEPS = 24;
    localparam longint X_START = 64'sd652032874;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 90;

    // arctan(2^-i) in 2^-32 turn
    localparam longint ARCTAN [ROT_STEPS] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10680094, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } frame_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [sosc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [sosc_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                last_of_block = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [15:0]                  left_sample;
    logic signed [15:0]                  right_sample;
    logic                                last;

    // oscillator state as the block should hold it
    logic [31:0]   phase_acc = '0;
    logic [31:0]   tune_word = 32'd42852281;
    logic [14:0]   gain = 15'd16384;

    bit            ticks_waiting[$];
    frame_t        frames_due[$];
    int            mismatches = 0;
    int            frames_seen = 0;
    bit            calm = 1'b0;

    sine_oscillator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .last_of_block(last_of_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last         (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // amplitude * sin(angle), rounded and clamped to 16 bits
    function automatic logic signed [15:0] sine_sample(input logic [31:0] angle,
                                                       input logic [14:0] amp);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint s;
        longint prod;
        logic [31:0] a;
        bit flip;
        int i;
        a = angle;
        flip = 1'b0;
        // fold the second and third quadrants by half a turn, negate later
        if (a[31:30] == 2'b01 || a[31:30] == 2'b10)
        begin
            a = a - 32'h8000_0000;
            flip = 1'b1;
        end
        x = X_START;
        y = 0;
        z = $signed(a);
        for (i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        s = flip ? -y : y;
        prod = (s * longint'(amp) + (longint'(1) <<< 29)) >>> 30;
        if (prod > 32767)
            prod = 32767;
        if (prod < -32768)
            prod = -32768;
        return prod[15:0];
    endfunction

    task automatic write_reg(input logic [sosc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == sosc_pkg::REG_PHASE_INCREMENT)
            tune_word = data;
        else if (idx == sosc_pkg::REG_AMPLITUDE)
            gain = data[sosc_pkg::AMP_BITS-1:0];
    endtask

    // wait for every frame to come back, then let the pipeline empty
    task automatic settle();
        while (ticks_waiting.size() != 0 || in_valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive
        frame_t f;
        int gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                f.left = sine_sample(phase_acc, gain);
                f.right = f.left;
                f.last = last_of_block;
                frames_due.push_back(f);
                phase_acc = phase_acc + tune_word;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (ticks_waiting.size() != 0 && !calm && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end
                else if (ticks_waiting.size() != 0)
                begin
                    in_valid <= 1'b1;
                    last_of_block <= ticks_waiting.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watch
        frame_t want;
        int stall_left;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected frame, expected none, got left %0d",
                             $time, left_sample);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (left_sample !== want.left)
                    begin
                        $display("%0t: left_sample expected %0d got %0d",
                                 $time, want.left, left_sample);
                        mismatches++;
                    end
                    if (right_sample !== want.right)
                    begin
                        $display("%0t: right_sample expected %0d got %0d",
                                 $time, want.right, right_sample);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0d got %0d", $time, want.last, last);
                        mismatches++;
                    end
                    frames_seen++;
                end
            end
            // one long hold mid-run so the pipeline fills and backs up
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && frames_seen >= 400)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int p;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset tuning and gain
        for (n = 0; n < 6; n++)
            ticks_waiting.push_back(n[0]);
        settle();

        // realign the accumulator to zero with one frame
        write_reg(sosc_pkg::REG_PHASE_INCREMENT, -phase_acc);
        ticks_waiting.push_back(1'b1);
        settle();

        // quadrant boundaries and the octants between, full gain
        write_reg(sosc_pkg::REG_PHASE_INCREMENT, 32'h2000_0000);
        write_reg(sosc_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
        for (n = 0; n < 9; n++)
            ticks_waiting.push_back(n[1]);
        settle();

        // half turns; upper data bits of the gain must be dropped
        write_reg(sosc_pkg::REG_PHASE_INCREMENT, 32'h8000_0000);
        write_reg(sosc_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_3, 32'h0000_0000);
        repeat (3) ticks_waiting.push_back(1'b0);
        settle();

        // largest step, gain of zero after masking
        write_reg(sosc_pkg::REG_PHASE_INCREMENT, 32'hFFFF_FFFF);
        write_reg(sosc_pkg::REG_AMPLITUDE, 32'hFFFF_8000);
        repeat (3) ticks_waiting.push_back(1'b1);
        settle();

        // frozen phase, smallest gain
        write_reg(sosc_pkg::REG_PHASE_INCREMENT, 32'h0000_0000);
        write_reg(sosc_pkg::REG_AMPLITUDE, 32'h0000_0001);
        ticks_waiting.push_back(1'b0);
        ticks_waiting.push_back(1'b1);
        settle();

        for (p = 0; p < 8; p++)
        begin
            if (p == 7)
                calm = 1'b1;
            case ($urandom_range(0, 4))
                0: write_reg(sosc_pkg::REG_PHASE_INCREMENT, $urandom_range(0, 1 << 20));
                1: write_reg(sosc_pkg::REG_PHASE_INCREMENT,
                             32'hFFFF_FFFF - $urandom_range(0, 255));
                default: write_reg(sosc_pkg::REG_PHASE_INCREMENT, $urandom());
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(sosc_pkg::REG_AMPLITUDE,
                             {17'($urandom_range(0, 131071)), 15'h7FFF});
                1: write_reg(sosc_pkg::REG_AMPLITUDE,
                             {17'($urandom_range(0, 131071)), 15'h0000});
                default: write_reg(sosc_pkg::REG_AMPLITUDE, $urandom());
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
            repeat (235) ticks_waiting.push_back(1'($urandom_range(0, 1)));
            settle();
        end

        if (frames_due.size() != 0)
        begin
            $display("%0t: %0d frames expected, none arrived", $time, frames_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("sine_oscillator test passed");
        else
            $display("sine_oscillator test failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("sine_oscillator test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sosc_pkg.sv
rtl/core/sosc_cordic_cell.sv
rtl/core/sosc_scaler.sv
rtl/core/sine_oscillator.sv
sim/tb.sv
